@@ src/utf8_to_escaped_code_transcoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the UTF-8 to escaped code transcoder
// Clocked implication checks, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_ESCAPED_CODE_TRANSCODER_CORE_MACROS_SVH
`define UTF8_TO_ESCAPED_CODE_TRANSCODER_CORE_MACROS_SVH

// same-cycle implication
`define U2E_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("transcoder check failed");

// next-cycle implication
`define U2E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("transcoder check failed");

`endif

@@ src/u2e_pkg.sv @@
// ----------------------------------------------------------------------------
// u2e_pkg
// Types and constants shared by the transcoder front, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package u2e_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    localparam logic [1:0] KIND_SINGLE   = 2'd0;
    localparam logic [1:0] KIND_ESC_LOW  = 2'd1;
    localparam logic [1:0] KIND_ESC_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] code;
    } cmd_t;

    localparam logic [7:0] ESC_MARK_ONE = 8'h01;
    localparam logic [7:0] ESC_MARK_TWO = 8'h02;

    localparam logic [7:0] CONT_MASK  = 8'h3f;
    localparam logic [7:0] LEAD4_MASK = 8'h07;
    localparam logic [7:0] LEAD3_MASK = 8'h0f;
    localparam logic [7:0] LEAD2_MASK = 8'h1f;

    localparam logic [1:0] STEP_FIRST  = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD  = 2'd2;

endpackage

`default_nettype wire

@@ src/utf8_to_escaped_code_transcoder_core.sv @@
// ----------------------------------------------------------------------------
// utf8_to_escaped_code_transcoder_core
// UTF-8 byte stream to escaped 16-bit code byte stream.
// ----------------------------------------------------------------------------
// The front end takes one UTF-8 byte per cycle while its command queue has
// room (QUEUE_DEPTH entries) and pushes one command per completed code. The
// back end sends one output byte per cycle while the output is not stalled:
// one byte for a code of 0xFF or less, three bytes for an escaped code, so
// the output port sets the sustained rate. The first output byte of a code
// passes through the queue entry and then the registered output stage
// before it is offered.
`default_nettype none

module utf8_to_escaped_code_transcoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                utf_valid,
    output logic                     utf_stall,
    input  wire u2e_pkg::in_item_t   utf_item,
    output logic                     esc_valid,
    input  wire logic                esc_stall,
    output u2e_pkg::out_item_t       esc_item
);

    logic          push;
    u2e_pkg::cmd_t push_cmd;
    logic          pop;
    u2e_pkg::cmd_t head_cmd;
    logic          empty;
    logic          full;

    u2e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .utf_valid  (utf_valid),
        .utf_stall  (utf_stall),
        .utf_item   (utf_item),
        .queue_full (full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    u2e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty),
        .full     (full)
    );

    u2e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .empty     (empty),
        .pop       (pop),
        .esc_valid (esc_valid),
        .esc_stall (esc_stall),
        .esc_item  (esc_item)
    );

endmodule

`default_nettype wire

@@ src/u2e_front.sv @@
// ----------------------------------------------------------------------------
// u2e_front
// Accepts UTF-8 bytes, tracks pending continuations and classifies each
// completed code into an output command.
// ----------------------------------------------------------------------------
`default_nettype none

module u2e_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            utf_valid,
    output logic                 utf_stall,
    input  wire u2e_pkg::in_item_t utf_item,
    input  wire logic            queue_full,
    output logic                 push,
    output u2e_pkg::cmd_t        push_cmd
);

    logic [1:0]  pend_reg;
    logic [1:0]  pend_next;
    logic [15:0] accum_reg;
    logic [15:0] accum_next;
    logic [1:0]  pend_cur;
    logic [15:0] accum_cur;
    logic [7:0]  b;
    logic        accept;
    logic        emit;
    logic [15:0] code;

    assign utf_stall = queue_full;
    assign accept    = utf_valid && !queue_full;
    assign b         = utf_item.in_byte;

    always_comb
    begin
        pend_cur   = utf_item.string_start ? 2'd0 : pend_reg;
        accum_cur  = utf_item.string_start ? 16'd0 : accum_reg;
        pend_next  = pend_cur;
        accum_next = accum_cur;
        emit       = 1'b0;
        code       = accum_cur;
        if (pend_cur != 2'd0)
        begin
            accum_next = {accum_cur[9:0], b[5:0] & u2e_pkg::CONT_MASK[5:0]};
            pend_next  = pend_cur - 2'd1;
            emit       = (pend_next == 2'd0);
            code       = accum_next;
        end
        else if (b inside {[8'hf0:8'hff]})
        begin
            pend_next  = 2'd3;
            accum_next = {8'h00, b & u2e_pkg::LEAD4_MASK};
        end
        else if (b inside {[8'he0:8'hef]})
        begin
            pend_next  = 2'd2;
            accum_next = {8'h00, b & u2e_pkg::LEAD3_MASK};
        end
        else if (b inside {[8'hc0:8'hdf]})
        begin
            pend_next  = 2'd1;
            accum_next = {8'h00, b & u2e_pkg::LEAD2_MASK};
        end
        else
        begin
            emit = 1'b1;
            code = {8'h00, b};
        end
    end

    always_comb
    begin
        push_cmd.code = code;
        if (code[15:8] == 8'h00)
            push_cmd.kind = u2e_pkg::KIND_SINGLE;
        else if (code[7:0] != 8'h00)
            push_cmd.kind = u2e_pkg::KIND_ESC_LOW;
        else
            push_cmd.kind = u2e_pkg::KIND_ESC_ZERO;
    end

    assign push = accept && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 2'd0;
            accum_reg <= 16'd0;
        end
        else if (accept)
        begin
            pend_reg  <= pend_next;
            accum_reg <= accum_next;
        end
    end

endmodule

`default_nettype wire

@@ src/u2e_queue.sv @@
// ----------------------------------------------------------------------------
// u2e_queue
// Small command queue between the decoder front and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module u2e_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire u2e_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output u2e_pkg::cmd_t      head_cmd,
    output logic               empty,
    output logic               full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    u2e_pkg::cmd_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   do_push;
    logic                   do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_CNT);
    assign head_cmd = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

endmodule

`default_nettype wire

@@ src/u2e_back.sv @@
// ----------------------------------------------------------------------------
// u2e_back
// Expands each queued command into one or three output bytes through a
// registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module u2e_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire u2e_pkg::cmd_t      head_cmd,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    esc_valid,
    input  wire logic               esc_stall,
    output u2e_pkg::out_item_t      esc_item
);

    logic                    out_valid_reg;
    logic                    out_valid_next;
    u2e_pkg::out_item_t      out_item_reg;
    u2e_pkg::out_item_t      out_item_next;
    logic [1:0]              step_reg;
    logic [1:0]              step_next;
    logic                    load;
    logic                    last;

    assign load = !empty && (!out_valid_reg || !esc_stall);

    always_comb
    begin
        out_item_next = out_item_reg;
        last          = 1'b0;
        case (head_cmd.kind)
            u2e_pkg::KIND_ESC_LOW:
            begin
                case (step_reg)
                    u2e_pkg::STEP_FIRST:  out_item_next.out_byte = u2e_pkg::ESC_MARK_ONE;
                    u2e_pkg::STEP_SECOND: out_item_next.out_byte = head_cmd.code[7:0];
                    default:
                    begin
                        out_item_next.out_byte = head_cmd.code[15:8];
                        last = 1'b1;
                    end
                endcase
            end
            u2e_pkg::KIND_ESC_ZERO:
            begin
                case (step_reg)
                    u2e_pkg::STEP_FIRST:  out_item_next.out_byte = u2e_pkg::ESC_MARK_TWO;
                    u2e_pkg::STEP_SECOND: out_item_next.out_byte = u2e_pkg::ESC_MARK_ONE;
                    default:
                    begin
                        out_item_next.out_byte = head_cmd.code[15:8];
                        last = 1'b1;
                    end
                endcase
            end
            default:
            begin
                out_item_next.out_byte = head_cmd.code[7:0];
                last = 1'b1;
            end
        endcase
        out_item_next.last_of_run = last;
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || !esc_stall)
            out_valid_next = !empty;
        if (load)
            step_next = last ? u2e_pkg::STEP_FIRST : step_reg + 2'd1;
    end

    assign pop       = load && last;
    assign esc_valid = out_valid_reg;
    assign esc_item  = out_item_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= u2e_pkg::STEP_FIRST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

endmodule

`default_nettype wire

@@ src/u2e_checker.sv @@
// ----------------------------------------------------------------------------
// u2e_checker
// Port-level checks for the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_to_escaped_code_transcoder_core_macros.svh"

module u2e_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               utf_valid,
    input  wire logic               utf_stall,
    input  wire logic               esc_valid,
    input  wire logic               esc_stall,
    input  wire u2e_pkg::out_item_t esc_item
);

    logic quiet;

    assign quiet = !esc_valid && !(utf_valid && !utf_stall);

    `U2E_ASSERT_NEXT(a_hold_stalled, esc_valid && esc_stall, esc_valid && $stable(esc_item))
    `U2E_ASSERT_SAME(a_drop_after_transfer, $fell(esc_valid), $past(!esc_stall))
    `U2E_ASSERT_NEXT(a_run_continues, esc_valid && !esc_stall && !esc_item.last_of_run, esc_valid)
    `U2E_ASSERT_NEXT(a_no_output_from_idle, quiet && $past(quiet), !esc_valid)

endmodule

bind utf8_to_escaped_code_transcoder_core u2e_checker u_u2e_checker (.*);

`default_nettype wire

@@ bench/u2e_escape_checker.sv @@
// ----------------------------------------------------------------------------
// u2e_escape_checker
// Watches both channels of the UTF-8 to escaped code transcoder, rebuilds
// each code from the accepted input bytes, queues the escaped bytes that it
// must produce and compares every output transaction with the oldest of them.
// ----------------------------------------------------------------------------
module u2e_escape_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                utf_valid,
    input  logic                utf_stall,
    input  u2e_pkg::in_item_t   utf_item,
    input  logic                esc_valid,
    input  logic                esc_stall,
    input  u2e_pkg::out_item_t  esc_item,
    output int                  fail_count,
    output int                  bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import u2e_pkg::*;

    localparam logic [7:0] LEAD2_BASE = 8'hc0;
    localparam logic [7:0] LEAD3_BASE = 8'he0;
    localparam logic [7:0] LEAD4_BASE = 8'hf0;

    logic [1:0]  conts_due;
    logic [15:0] code_value;
    out_item_t   escaped_bytes_due[$];
    int          mismatch_total;

    assign fail_count = mismatch_total;

    task automatic flag_mismatch(input string what);
        $display("u2e_escape_checker: %s at %0t", what, $realtime);
        mismatch_total++;
    endtask

    task automatic owe_byte(input logic [7:0] b, input logic last);
        out_item_t o;
        o.out_byte = b;
        o.last_of_run = last;
        escaped_bytes_due.push_back(o);
    endtask

    task automatic absorb_byte(input in_item_t it);
        logic [7:0] b;
        b = it.in_byte;
        if (it.string_start)
        begin
            conts_due = 2'd0;
            code_value = 16'h0000;
        end
        if (conts_due != 2'd0)
        begin
            code_value = (code_value << 6) | 16'(b & CONT_MASK);
            conts_due = conts_due - 2'd1;
            if (conts_due == 2'd0)
            begin
                if (code_value <= 16'h00ff)
                begin
                    owe_byte(code_value[7:0], 1'b1);
                end
                else if (code_value[7:0] != 8'h00)
                begin
                    owe_byte(ESC_MARK_ONE, 1'b0);
                    owe_byte(code_value[7:0], 1'b0);
                    owe_byte(code_value[15:8], 1'b1);
                end
                else
                begin
                    owe_byte(ESC_MARK_TWO, 1'b0);
                    owe_byte(ESC_MARK_ONE, 1'b0);
                    owe_byte(code_value[15:8], 1'b1);
                end
            end
        end
        else if (b >= LEAD4_BASE)
        begin
            conts_due = 2'd3;
            code_value = 16'(b & LEAD4_MASK);
        end
        else if (b >= LEAD3_BASE)
        begin
            conts_due = 2'd2;
            code_value = 16'(b & LEAD3_MASK);
        end
        else if (b >= LEAD2_BASE)
        begin
            conts_due = 2'd1;
            code_value = 16'(b & LEAD2_MASK);
        end
        else
        begin
            owe_byte(b, 1'b1);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            conts_due = 2'd0;
            code_value = 16'h0000;
            escaped_bytes_due.delete();
            mismatch_total = 0;
            bytes_owed <= 0;
        end
        else
        begin
            if (esc_valid && !esc_stall)
            begin
                if (escaped_bytes_due.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected output byte %02h last %b",
                                            esc_item.out_byte, esc_item.last_of_run));
                end
                else
                begin
                    want = escaped_bytes_due.pop_front();
                    if (esc_item.out_byte !== want.out_byte)
                        flag_mismatch($sformatf("out_byte %02h, expected %02h",
                                                esc_item.out_byte, want.out_byte));
                    if (esc_item.last_of_run !== want.last_of_run)
                        flag_mismatch($sformatf("last_of_run %b, expected %b",
                                                esc_item.last_of_run, want.last_of_run));
                end
            end
            if (utf_valid && !utf_stall)
                absorb_byte(utf_item);
            bytes_owed <= escaped_bytes_due.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives UTF-8 byte streams into the transcoder: a directed opening over the
// corner cases, then random well-formed, truncated and malformed sequences
// with random idling on both sides, one long output hold-off and a drain.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u2e_pkg::*;

    localparam int ITEM_TARGET  = 220;
    localparam int HOLD_CYCLES  = 120;
    localparam int TAIL_CYCLES  = 16;
    localparam int LIMIT_CYCLES = 300000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      utf_valid;
    logic      utf_stall;
    in_item_t  utf_item;
    logic      esc_valid;
    logic      esc_stall;
    out_item_t esc_item;

    int   fail_count;
    int   bytes_owed;
    int   cycles = 0;
    int   sent;
    logic hold_req;
    logic steady;

    utf8_to_escaped_code_transcoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .utf_valid (utf_valid),
        .utf_stall (utf_stall),
        .utf_item  (utf_item),
        .esc_valid (esc_valid),
        .esc_stall (esc_stall),
        .esc_item  (esc_item)
    );

    u2e_escape_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .utf_valid  (utf_valid),
        .utf_stall  (utf_stall),
        .utf_item   (utf_item),
        .esc_valid  (esc_valid),
        .esc_stall  (esc_stall),
        .esc_item   (esc_item),
        .fail_count (fail_count),
        .bytes_owed (bytes_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // mostly no gap, some short, a few long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer(input logic [7:0] b, input logic s);
        int gap;
        utf_item <= '{in_byte: b, string_start: s};
        utf_valid <= 1'b1;
        @(posedge clk);
        while (utf_stall)
            @(posedge clk);
        sent++;
        gap = steady ? 0 : idle_span();
        if (gap != 0)
        begin
            utf_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // lead byte of a code of len bytes, then keep continuation bytes
    task automatic send_code(input int len, input logic s, input int keep);
        logic [7:0] lead;
        case (len)
            1: lead = 8'($urandom_range(8'h00, 8'h7f));
            2: lead = 8'($urandom_range(8'hc0, 8'hdf));
            3: lead = 8'($urandom_range(8'he0, 8'hef));
            default: lead = 8'($urandom_range(8'hf0, 8'hff));
        endcase
        offer(lead, s);
        repeat (keep) offer(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
    endtask

    task automatic settle();
        utf_valid <= 1'b0;
        @(posedge clk);
        @(posedge clk);
        while (bytes_owed != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int   stall_left;
        logic held;
        stall_left = 0;
        held = 1'b0;
        esc_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1'b1;
                esc_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left != 0)
            begin
                stall_left--;
            end
            else if (steady)
            begin
                esc_stall <= 1'b0;
            end
            else
            begin
                stall_left = idle_span();
                esc_stall <= (stall_left != 0);
            end
        end
    end

    initial
    begin
        int   pick;
        int   len;
        logic s;
        logic force_start;
        rst_n = 1'b0;
        utf_valid = 1'b0;
        utf_item = '0;
        hold_req = 1'b0;
        steady = 1'b0;
        sent = 0;
        force_start = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain, stray continuation, small and escaped codes
        offer(8'h00, 1'b0);
        offer(8'h7f, 1'b0);
        offer(8'h80, 1'b0);
        offer(8'hc3, 1'b0);
        offer(8'ha9, 1'b0);
        offer(8'hc0, 1'b0);
        offer(8'h80, 1'b0);
        offer(8'he4, 1'b0);
        offer(8'hb8, 1'b0);
        offer(8'h80, 1'b0);
        offer(8'hef, 1'b0);
        offer(8'hbf, 1'b0);
        offer(8'hbf, 1'b0);
        // four-byte code, truncated
        offer(8'hf0, 1'b0);
        offer(8'h9f, 1'b0);
        offer(8'h98, 1'b0);
        offer(8'h80, 1'b0);
        // ascii taken as continuation
        offer(8'hc3, 1'b0);
        offer(8'h41, 1'b0);
        // drop an unfinished sequence
        offer(8'he4, 1'b0);
        offer(8'hb8, 1'b0);
        offer(8'h41, 1'b1);
        offer(8'hff, 1'b1);
        offer(8'hbf, 1'b0);
        offer(8'hfe, 1'b0);
        settle();

        hold_req <= 1'b1;
        while (sent < ITEM_TARGET)
        begin
            steady <= (sent >= 130 && sent < 170);
            pick = $urandom_range(0, 99);
            s = force_start || ($urandom_range(0, 9) == 0);
            force_start = 1'b0;
            if (pick < 30)
            begin
                send_code(1, s, 0);
            end
            else if (pick < 50)
            begin
                send_code(2, s, 1);
            end
            else if (pick < 68)
            begin
                send_code(3, s, 2);
            end
            else if (pick < 78)
            begin
                send_code(4, s, 3);
            end
            else if (pick < 86)
            begin
                len = $urandom_range(2, 4);
                send_code(len, s, $urandom_range(0, len - 2));
                force_start = ($urandom_range(0, 1) == 1);
            end
            else if (pick < 93)
            begin
                len = $urandom_range(2, 4);
                send_code(len, s, 0);
                repeat (len - 1) offer(8'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        end
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
